[sv/vgd_pkg.sv]
package vgd_pkg;

    localparam int CAPACITY   = 64;
    localparam int COUNT_BITS = 16;

    localparam int POS_W   = 24;
    localparam int INT_W   = 16;
    localparam int VOX_W   = 16;
    localparam int SUM_W   = 40;
    localparam int ISUM_W  = 32;
    localparam int DIV_W   = (COUNT_BITS > VOX_W) ? COUNT_BITS : VOX_W;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam logic [VOX_W-1:0] VOX_RESET = VOX_W'(205);

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_CLEAR   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UPD,
        S_EX_RD,
        S_EX_WAIT,
        S_EX_DIV,
        S_EX_WR,
        S_SEL_RD,
        S_SEL_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        t_kind                    kind;
        logic signed [POS_W-1:0]  x_pos;
        logic signed [POS_W-1:0]  y_pos;
        logic signed [POS_W-1:0]  z_pos;
        logic [INT_W-1:0]         intensity;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0]  avg_x;
        logic signed [POS_W-1:0]  avg_y;
        logic signed [POS_W-1:0]  avg_z;
        logic [INT_W-1:0]         avg_intensity;
        logic                     last_point;
        logic                     overflowed;
    } t_out;

    typedef struct packed {
        logic signed [POS_W-1:0]  key_x;
        logic signed [POS_W-1:0]  key_y;
        logic signed [POS_W-1:0]  key_z;
        logic signed [SUM_W-1:0]  sum_x;
        logic signed [SUM_W-1:0]  sum_y;
        logic signed [SUM_W-1:0]  sum_z;
        logic [ISUM_W-1:0]        sum_i;
        logic [COUNT_BITS-1:0]    count;
    } t_row;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic [INT_W-1:0]         i;
    } t_avg;

    function automatic logic avg_less(input t_avg a, input t_avg b);
        logic res;
        if (a.x != b.x) begin
            res = (a.x < b.x);
        end else if (a.y != b.y) begin
            res = (a.y < b.y);
        end else begin
            res = (a.z < b.z);
        end
        return res;
    endfunction

endpackage

[sv/vgd_div.sv]
module vgd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [vgd_pkg::SUM_W-1:0]    i_dividend,
    input  logic [vgd_pkg::DIV_W-1:0]           i_divisor,
    output logic                                o_done,
    output logic signed [vgd_pkg::SUM_W-1:0]    o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [vgd_pkg::STEP_W-1:0]     r_cnt;
    logic [vgd_pkg::SUM_W-1:0]      r_mag;
    logic [vgd_pkg::DIV_W-1:0]      r_rem;
    logic [vgd_pkg::DIV_W-1:0]      r_div;
    logic                           r_neg;

    logic [vgd_pkg::DIV_W:0]        trial;
    logic                           fits;

    assign trial = {r_rem, r_mag[vgd_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[vgd_pkg::SUM_W-1];
                r_mag  <= i_dividend[vgd_pkg::SUM_W-1] ? (-i_dividend) : i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // Restoring division: the quotient bits shift in behind the dividend.
                r_mag <= {r_mag[vgd_pkg::SUM_W-2:0], fits};
                r_rem <= fits ? vgd_pkg::DIV_W'(trial - {1'b0, r_div})
                              : vgd_pkg::DIV_W'(trial);
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == vgd_pkg::STEP_W'(vgd_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Floor rounding: a negative dividend with a remainder steps one further down.
    assign o_quot = !r_neg ? r_mag : ((r_rem != '0) ? ~r_mag : -r_mag);
    assign o_done = r_done;

endmodule

[sv/voxel_grid_downsampler_core.sv]
// Voxel-grid downsampler. Command beats arrive on i_in_valid / o_in_stall carrying
// a kind (insert, extract or clear) and a point. Result beats leave on o_out_valid /
// i_out_stall, one per occupied cell, and only for an extract. The voxel edge length
// is written on the i_cfg_valid / o_cfg_ready channel, which is always ready.
// One command is worked on at a time and o_in_stall stays high until it is done.
// An insert runs the three floored key divisions, which share one bit-serial divider,
// then scans the cell table memory and ends with the read-modify-write.
// An extract first forms the averages of each occupied cell in the divider, then
// sorts by repeated minimum passes over an average memory: each result waits in the
// output register for as long as the receiver stalls. Clear and unused kinds are
// handled while idle and raise no stall.
// Reset empties the table, clears the overflow flag, sets the voxel size to 205
// and drops any pending result; no clearing pass is needed since the occupancy
// bits are flip-flops.
module voxel_grid_downsampler_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vgd_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vgd_pkg::t_out               o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vgd_pkg::VOX_W-1:0]   i_cfg_data
);

    localparam int CAP = vgd_pkg::CAPACITY;
    localparam int IW  = vgd_pkg::IDX_W;
    localparam int CW  = vgd_pkg::CNT_W;
    localparam int PW  = vgd_pkg::POS_W;
    localparam int SW  = vgd_pkg::SUM_W;

    vgd_pkg::t_state              r_state, n_state;
    vgd_pkg::t_in                 r_cmd, n_cmd;
    logic [1:0]                   r_part, n_part;
    logic                         r_go, n_go;
    logic signed [PW-1:0]         r_key [3];
    logic signed [PW-1:0]         n_key [3];
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_hit, n_hit;
    logic [IW-1:0]                r_hit_idx, n_hit_idx;
    logic                         r_free_ok, n_free_ok;
    logic [IW-1:0]                r_free_idx, n_free_idx;
    vgd_pkg::t_row                r_row, n_row;
    logic [CAP-1:0]               r_valid, n_valid;
    logic [CAP-1:0]               r_emitted, n_emitted;
    logic                         r_ovf, n_ovf;
    logic [vgd_pkg::VOX_W-1:0]    r_vox;
    logic [CW-1:0]                r_n, n_n;
    logic [CW-1:0]                r_sent, n_sent;
    logic                         r_have, n_have;
    vgd_pkg::t_avg                r_min, n_min;
    logic [IW-1:0]                r_min_idx, n_min_idx;
    vgd_pkg::t_avg                r_avg, n_avg;
    logic                         r_out_valid, n_out_valid;
    vgd_pkg::t_out                r_out, n_out;

    vgd_pkg::t_row                tbl_mem [CAP];
    vgd_pkg::t_row                r_tbl_rd;
    logic                         tbl_we;
    logic [IW-1:0]                tbl_waddr;
    vgd_pkg::t_row                tbl_wdata;

    vgd_pkg::t_avg                avg_mem [CAP];
    vgd_pkg::t_avg                r_avg_rd;
    logic                         avg_we;

    logic [IW-1:0]                cur;
    logic signed [SW-1:0]         div_dividend;
    logic [vgd_pkg::DIV_W-1:0]    div_divisor;
    logic                         div_done;
    logic signed [SW-1:0]         div_quot;

    assign cur = r_idx[IW-1:0];

    always_comb begin
        div_dividend = '0;
        div_divisor  = '0;
        if (r_cmd.kind == vgd_pkg::KIND_EXTRACT) begin
            div_divisor = vgd_pkg::DIV_W'(r_row.count);
            case (r_part)
                2'd0:    div_dividend = r_row.sum_x;
                2'd1:    div_dividend = r_row.sum_y;
                2'd2:    div_dividend = r_row.sum_z;
                default: div_dividend = SW'(r_row.sum_i);
            endcase
        end else begin
            // A voxel size of zero behaves as one.
            div_divisor = (r_vox == '0) ? vgd_pkg::DIV_W'(1) : vgd_pkg::DIV_W'(r_vox);
            case (r_part)
                2'd0:    div_dividend = {{(SW-PW){r_cmd.x_pos[PW-1]}}, r_cmd.x_pos};
                2'd1:    div_dividend = {{(SW-PW){r_cmd.y_pos[PW-1]}}, r_cmd.y_pos};
                default: div_dividend = {{(SW-PW){r_cmd.z_pos[PW-1]}}, r_cmd.z_pos};
            endcase
        end
    end

    vgd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_part      = r_part;
        n_go        = 1'b0;
        n_key       = r_key;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_row       = r_row;
        n_valid     = r_valid;
        n_emitted   = r_emitted;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_sent      = r_sent;
        n_have      = r_have;
        n_min       = r_min;
        n_min_idx   = r_min_idx;
        n_avg       = r_avg;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        tbl_we      = 1'b0;
        tbl_waddr   = r_hit_idx;
        tbl_wdata   = r_row;
        avg_we      = 1'b0;

        case (r_state)
            vgd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data;
                    case (i_in_data.kind)
                        vgd_pkg::KIND_INSERT: begin
                            n_part  = 2'd0;
                            n_go    = 1'b1;
                            n_state = vgd_pkg::S_DIVK;
                        end
                        vgd_pkg::KIND_EXTRACT: begin
                            n_idx     = '0;
                            n_n       = '0;
                            n_sent    = '0;
                            n_emitted = '0;
                            n_state   = vgd_pkg::S_EX_RD;
                        end
                        vgd_pkg::KIND_CLEAR: begin
                            n_valid = '0;
                            n_ovf   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            vgd_pkg::S_DIVK: begin
                if (div_done) begin
                    n_key[r_part] = div_quot[PW-1:0];
                    if (r_part == 2'd2) begin
                        n_idx     = '0;
                        n_hit     = 1'b0;
                        n_free_ok = 1'b0;
                        n_state   = vgd_pkg::S_SCAN_RD;
                    end else begin
                        n_part = r_part + 2'd1;
                        n_go   = 1'b1;
                    end
                end
            end

            vgd_pkg::S_SCAN_RD: begin
                n_state = vgd_pkg::S_SCAN_CMP;
            end

            vgd_pkg::S_SCAN_CMP: begin
                if (r_valid[cur]) begin
                    if (!r_hit && r_tbl_rd.key_x == r_key[0] && r_tbl_rd.key_y == r_key[1]
                            && r_tbl_rd.key_z == r_key[2]) begin
                        n_hit     = 1'b1;
                        n_hit_idx = cur;
                        n_row     = r_tbl_rd;
                    end
                end else if (!r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = cur;
                end
                if (r_idx == CW'(CAP - 1)) begin
                    n_state = vgd_pkg::S_UPD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = vgd_pkg::S_SCAN_RD;
                end
            end

            vgd_pkg::S_UPD: begin
                n_state = vgd_pkg::S_IDLE;
                tbl_wdata.key_x = r_key[0];
                tbl_wdata.key_y = r_key[1];
                tbl_wdata.key_z = r_key[2];
                tbl_wdata.sum_x = r_row.sum_x + {{(SW-PW){r_cmd.x_pos[PW-1]}}, r_cmd.x_pos};
                tbl_wdata.sum_y = r_row.sum_y + {{(SW-PW){r_cmd.y_pos[PW-1]}}, r_cmd.y_pos};
                tbl_wdata.sum_z = r_row.sum_z + {{(SW-PW){r_cmd.z_pos[PW-1]}}, r_cmd.z_pos};
                tbl_wdata.sum_i = r_row.sum_i + vgd_pkg::ISUM_W'(r_cmd.intensity);
                tbl_wdata.count = r_row.count + 1'b1;
                if (r_hit) begin
                    if (r_row.count == {vgd_pkg::COUNT_BITS{1'b1}}) begin
                        n_ovf = 1'b1;
                    end else begin
                        tbl_we = 1'b1;
                    end
                end else if (r_free_ok) begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = r_free_idx;
                    tbl_wdata.sum_x = {{(SW-PW){r_cmd.x_pos[PW-1]}}, r_cmd.x_pos};
                    tbl_wdata.sum_y = {{(SW-PW){r_cmd.y_pos[PW-1]}}, r_cmd.y_pos};
                    tbl_wdata.sum_z = {{(SW-PW){r_cmd.z_pos[PW-1]}}, r_cmd.z_pos};
                    tbl_wdata.sum_i = vgd_pkg::ISUM_W'(r_cmd.intensity);
                    tbl_wdata.count = vgd_pkg::COUNT_BITS'(1);
                    n_valid[r_free_idx] = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end

            vgd_pkg::S_EX_RD: begin
                if (r_idx == CW'(CAP)) begin
                    if (r_n == '0) begin
                        n_state = vgd_pkg::S_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_have  = 1'b0;
                        n_state = vgd_pkg::S_SEL_RD;
                    end
                end else if (!r_valid[cur]) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = vgd_pkg::S_EX_WAIT;
                end
            end

            vgd_pkg::S_EX_WAIT: begin
                n_row   = r_tbl_rd;
                n_part  = 2'd0;
                n_go    = 1'b1;
                n_state = vgd_pkg::S_EX_DIV;
            end

            vgd_pkg::S_EX_DIV: begin
                if (div_done) begin
                    case (r_part)
                        2'd0:    n_avg.x = div_quot[PW-1:0];
                        2'd1:    n_avg.y = div_quot[PW-1:0];
                        2'd2:    n_avg.z = div_quot[PW-1:0];
                        default: n_avg.i = div_quot[vgd_pkg::INT_W-1:0];
                    endcase
                    if (r_part == 2'd3) begin
                        n_state = vgd_pkg::S_EX_WR;
                    end else begin
                        n_part = r_part + 2'd1;
                        n_go   = 1'b1;
                    end
                end
            end

            vgd_pkg::S_EX_WR: begin
                avg_we  = 1'b1;
                n_n     = r_n + 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = vgd_pkg::S_EX_RD;
            end

            vgd_pkg::S_SEL_RD: begin
                if (r_idx == CW'(CAP)) begin
                    n_out.avg_x         = r_min.x;
                    n_out.avg_y         = r_min.y;
                    n_out.avg_z         = r_min.z;
                    n_out.avg_intensity = r_min.i;
                    n_out.last_point    = ((r_sent + 1'b1) == r_n);
                    n_out.overflowed    = r_ovf;
                    n_out_valid         = 1'b1;
                    n_emitted[r_min_idx] = 1'b1;
                    n_sent              = r_sent + 1'b1;
                    n_state             = vgd_pkg::S_OUT;
                end else if (!r_valid[cur] || r_emitted[cur]) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = vgd_pkg::S_SEL_CMP;
                end
            end

            vgd_pkg::S_SEL_CMP: begin
                // Strict compare keeps the lower table index on a tie.
                if (!r_have || vgd_pkg::avg_less(r_avg_rd, r_min)) begin
                    n_have    = 1'b1;
                    n_min     = r_avg_rd;
                    n_min_idx = cur;
                end
                n_idx   = r_idx + 1'b1;
                n_state = vgd_pkg::S_SEL_RD;
            end

            vgd_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_sent == r_n) begin
                        n_state = vgd_pkg::S_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_have  = 1'b0;
                        n_state = vgd_pkg::S_SEL_RD;
                    end
                end
            end

            default: begin
                n_state = vgd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vgd_pkg::S_IDLE;
            r_go        <= 1'b0;
            r_valid     <= '0;
            r_ovf       <= 1'b0;
            r_vox       <= vgd_pkg::VOX_RESET;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_sent      <= '0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_valid     <= n_valid;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_sent      <= n_sent;
            if (i_cfg_valid) begin
                r_vox <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_part     <= n_part;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_row      <= n_row;
        r_emitted  <= n_emitted;
        r_have     <= n_have;
        r_min      <= n_min;
        r_min_idx  <= n_min_idx;
        r_avg      <= n_avg;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rd <= tbl_mem[cur];
    end

    always_ff @(posedge i_clk) begin
        if (avg_we) begin
            avg_mem[cur] <= r_avg;
        end
        r_avg_rd <= avg_mem[cur];
    end

    assign o_in_stall  = (r_state != vgd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent <= r_n)
        else $error("more results sent than cells counted");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_point) |-> (r_sent == r_n))
        else $error("last_point on a result that is not the final one");

    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !r_out_valid)
        else $error("new command taken while a result is still pending");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |=> !div_done)
        else $error("divider reported done straight after a start");

endmodule
